>>> src/pcl_pkg.sv
package pcl_pkg;

  localparam int DEF_CAPACITY   = 32;
  localparam int DEF_VALUE_BITS = 32;
  localparam int OUT_BITS       = 32;
  localparam int POS_BITS       = 6;
  localparam int LEN_BITS       = 6;

  // Request codes.
  localparam logic [2:0] REQ_READ     = 3'd0;
  localparam logic [2:0] REQ_COUNT    = 3'd1;
  localparam logic [2:0] REQ_INS_HEAD = 3'd2;
  localparam logic [2:0] REQ_INS_TAIL = 3'd3;
  localparam logic [2:0] REQ_INS_AT   = 3'd4;
  localparam logic [2:0] REQ_DEL_HEAD = 3'd5;
  localparam logic [2:0] REQ_DEL_TAIL = 3'd6;
  localparam logic [2:0] REQ_DEL_AT   = 3'd7;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // Classified operation handed from front to back.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  status;
    logic        at_head;
    logic [31:0] value;
    logic [6:0]  index;
  } pcl_cmd_t;

endpackage

>>> src/pcl_ram.sv
module pcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/pcl_front.sv
module pcl_front import pcl_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [31:0]       item_value,
  input  logic [POS_BITS-1:0] position,
  output logic              cmd_valid,
  input  logic              cmd_stall,
  output pcl_cmd_t          cmd
);

  localparam int CW = $clog2(CAPACITY + 1);

  // The front keeps its own count, updated as each request is classified,
  // so the back only carries out checked work.
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [POS_BITS:0] pos_w;
  logic [POS_BITS:0] cnt_w;
  logic             full;
  logic             empty;
  pcl_cmd_t         c;

  // Two-entry queue toward the back.
  pcl_cmd_t q [2];
  logic [1:0] q_cnt;
  logic       push;
  logic       pop;
  logic       push_front;

  assign pos_w = {1'b0, position};
  assign cnt_w = (POS_BITS + 1)'(count);
  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  always_comb begin
    c.op      = OP_NONE;
    c.status  = ST_OK;
    c.at_head = 1'b0;
    c.value   = item_value;
    c.index   = '0;
    count_next = count;
    case (req_type)
      REQ_READ: begin
        c.op = empty ? OP_NONE : OP_READ;
        c.status = empty ? ST_EMPTY : ST_OK;
      end
      REQ_COUNT: begin
      end
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_AT: begin
        if (full) begin
          c.status = ST_FULL;
        end else if (req_type == REQ_INS_AT &&
                     (pos_w == '0 || pos_w > cnt_w + 1'b1)) begin
          c.status = ST_RANGE;
        end else begin
          c.op = OP_INS;
          c.at_head = (req_type == REQ_INS_HEAD);
          c.index = (req_type == REQ_INS_HEAD) ? '0 :
                    (req_type == REQ_INS_TAIL) ? 7'(count) : 7'(pos_w - 1'b1);
          if (req_type == REQ_INS_AT && pos_w == 1) begin
            c.at_head = 1'b1;
          end
          count_next = count + 1'b1;
        end
      end
      default: begin
        if (empty) begin
          c.status = ST_EMPTY;
        end else if (req_type == REQ_DEL_AT && (pos_w == '0 || pos_w > cnt_w)) begin
          c.status = ST_RANGE;
        end else begin
          c.op = OP_DEL;
          c.index = (req_type == REQ_DEL_HEAD) ? '0 :
                    (req_type == REQ_DEL_TAIL) ? 7'(count - 1'b1) : 7'(pos_w - 1'b1);
          c.at_head = (c.index == '0);
          count_next = count - 1'b1;
        end
      end
    endcase
  end

  assign in_stall   = (q_cnt == 2'd2);
  assign push       = in_valid && !in_stall;
  assign cmd_valid  = (q_cnt != 2'd0);
  assign pop        = cmd_valid && !cmd_stall;
  assign cmd        = q[0];
  assign push_front = push && (q_cnt == 2'd0 || (q_cnt == 2'd1 && pop));

  // Queue bookkeeping and the front count.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
      count <= '0;
    end else begin
      q_cnt <= q_cnt + {1'b0, push} - {1'b0, pop};
      if (push) begin
        count <= count_next;
      end
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push_front) begin
      q[0] <= c;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (push && !push_front) begin
      q[1] <= c;
    end
  end

endmodule

>>> src/pcl_back.sv
module pcl_back import pcl_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  pcl_cmd_t            cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_value,
  output logic [LEN_BITS-1:0] list_length,
  output logic [1:0]          status,
  output logic                last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]   state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  pcl_cmd_t     cur;
  logic [CW-1:0] i;       // walk index
  logic         rd_pend;  // read data from the RAM is valid
  logic [CW-1:0] rd_idx;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic [CW-1:0] rd_log;
  logic [CW-1:0] wr_log;
  logic         out_free;
  logic         out_load;

  // Logical index to ring slot.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(k);
    if (s >= (CW + 1)'(CAPACITY)) begin
      s = s - (CW + 1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  pcl_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign out_free  = !out_valid || !out_stall;
  assign cmd_stall = (state != S_IDLE);
  assign out_load  = out_free && ((state == S_READ && rd_pend) || state == S_EMIT);

  // Read and write addresses of the current step.
  always_comb begin
    rd_log  = i;
    wr_log  = i;
    wr_en   = 1'b0;
    wr_data = rd_data;
    if (state == S_MOVE) begin
      if (cur.op == OP_INS) begin
        rd_log = i - 1'b1;           // shift up: slot(i) <- slot(i-1)
        wr_log = rd_idx + 1'b1;
      end else begin
        rd_log = i + 1'b1;           // shift down: slot(i) <- slot(i+1)
        wr_log = rd_idx - 1'b1;
      end
      wr_en = rd_pend;
    end else if (state == S_WRITE) begin
      wr_en   = 1'b1;
      wr_log  = CW'(cur.index);
      wr_data = VALUE_BITS'(signed'(cur.value));
    end
    rd_addr = slot(head, rd_log);
    wr_addr = slot(head, wr_log);
  end

  // Output valid: set when a result is loaded, cleared once it transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rd_pend   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_pend <= 1'b0;
          if (cmd_valid) begin
            cur <= cmd;
            case (cmd.op)
              OP_READ: begin
                i <= '0;
                state <= S_READ;
              end
              OP_INS: begin
                if (cmd.at_head) begin
                  head <= (head == '0) ? AW'(CAPACITY - 1) : head - 1'b1;
                  state <= S_WRITE;
                end else begin
                  i <= count;
                  state <= (CW'(cmd.index) == count) ? S_WRITE : S_MOVE;
                end
              end
              OP_DEL: begin
                if (cmd.at_head) begin
                  head <= (head == AW'(CAPACITY - 1)) ? '0 : head + 1'b1;
                  count <= count - 1'b1;
                  state <= S_EMIT;
                end else begin
                  i <= CW'(cmd.index);
                  state <= S_MOVE;
                end
              end
              default: begin
                state <= S_EMIT;
              end
            endcase
          end
        end
        // Walk read-out: read slot i from the registered RAM, then load it into the output once the output is free.
        S_READ: begin
          if (!rd_pend) begin
            rd_pend <= 1'b1;
          end else if (out_free) begin
            out_value   <= 32'(signed'(rd_data));
            list_length <= LEN_BITS'(count);
            status      <= ST_OK;
            last        <= (i + 1'b1 == count);
            rd_pend     <= 1'b0;
            if (i + 1'b1 == count) begin
              state <= S_IDLE;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        // Shift one entry per read; the write lands when data returns.
        S_MOVE: begin
          rd_idx <= rd_log;
          if (cur.op == OP_INS) begin
            if (i > CW'(cur.index)) begin
              rd_pend <= 1'b1;
              i <= i - 1'b1;
            end else begin
              rd_pend <= 1'b0;
              if (!rd_pend) begin
                state <= S_WRITE;
              end
            end
          end else begin
            if (i + 1'b1 < count) begin
              rd_pend <= 1'b1;
              i <= i + 1'b1;
            end else begin
              rd_pend <= 1'b0;
              if (!rd_pend) begin
                count <= count - 1'b1;
                state <= S_EMIT;
              end
            end
          end
        end
        S_WRITE: begin
          count <= count + 1'b1;
          state <= S_EMIT;
        end
        // Single status transfer.
        S_EMIT: begin
          if (out_free) begin
            out_value   <= '0;
            list_length <= LEN_BITS'(count);
            status      <= cur.status;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/positional_circular_list.sv
// Positional circular list: an ordered list of up to CAPACITY signed values
// held in a ring buffer memory.
// Input channel: in_valid / in_stall with req_type, item_value, position.
// Output channel: out_valid / out_stall with out_value, list_length, status
// and last. A read-out gives one transfer per element, the final one marked
// by last; every other request gives one transfer.
// A front stage checks each request against its own running count and
// pushes a command into a two-entry queue; the back sequencer carries it out
// on a single-port-write, registered-read RAM.
// A positional insert or delete shifts the entries after the position one
// at a time through the registered RAM read before its result; a head
// insert, a tail insert, a head delete or a tail delete moves no entries. A
// read-out reads each element from the registered RAM before presenting it.
// Reset empties the list at once; no clearing pass is needed.
// While the receiver stalls, the held transfer stays put and the sequencer
// waits; the queue then fills and in_stall rises.
module positional_circular_list import pcl_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          req_type,
  input  logic signed [31:0]  item_value,
  input  logic [POS_BITS-1:0] position,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_value,
  output logic [LEN_BITS-1:0] list_length,
  output logic [1:0]          status,
  output logic                last
);

  pcl_cmd_t cmd;
  logic     cmd_valid;
  logic     cmd_stall;

  pcl_front #(.CAPACITY(CAPACITY)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .item_value(item_value), .position(position),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd)
  );

  pcl_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .cmd(cmd), .out_valid(out_valid), .out_stall(out_stall),
    .out_value(out_value), .list_length(list_length), .status(status),
    .last(last)
  );

  // The reported length never exceeds the capacity.
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (list_length <= LEN_BITS'(CAPACITY)))
    else $error("list length beyond capacity");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(last))
    else $error("stalled result changed");

  // Results with a failing status carry a zero value.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> out_value == '0)
    else $error("status result with nonzero value");

endmodule
